### src/assert_macros.svh
// assertion macros shared by the rtl of the device code table
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked on the rising edge outside reset
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked on the rising edge outside reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### src/hdct_pkg.sv
// shared constants, codes and types of the hashed device code table
// no dependencies
package hdct_pkg;

  // table geometry; BUCKETS must be a power of two
  localparam int BUCKETS  = 32;
  localparam int WAYS     = 4;
  localparam int SLOTS    = BUCKETS * WAYS;
  localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // field widths
  localparam int KIND_W   = 2;
  localparam int CODE_W   = 64;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

  // write port of the slot store: fill a slot or drop its valid bit
  typedef struct packed {
    logic                fill;
    logic                drop;
    logic [SLOT_W-1:0]   idx;
    logic [CODE_W-1:0]   code;
    logic [HANDLE_W-1:0] handle;
  } slot_wr_t;

  // registered read data of the slot store
  typedef struct packed {
    logic                vld;
    logic [CODE_W-1:0]   code;
    logic [HANDLE_W-1:0] handle;
  } slot_rd_t;

  // slot index = bucket * WAYS + way
  function automatic logic [SLOT_W-1:0] slot_of(input logic [BUCKET_W-1:0] bucket,
                                                input logic [WAY_W-1:0]    way);
    int unsigned s;
    s = int'(bucket) * WAYS + int'(way);
    return s[SLOT_W-1:0];
  endfunction

endpackage

### src/hashed_device_code_table_core.sv
// top level of the hashed device code table: sequencer, shared code compare, result register
// depends on hdct_pkg, hdct_slot_store and assert_macros.svh
//
// Maps 64-bit device codes to 32-bit handles in BUCKETS buckets of WAYS slots each; the bucket
// is the low bits of the code. One request is handled at a time: after acceptance the sequencer
// walks the bucket one way at a time (a READ state for the registered memory read, then a CMP
// state for one 64-bit code compare), stops early on a match, then applies the update and loads
// the result register together in the APPLY state. A request holds the input until the sequencer
// is idle again; from 1 to WAYS ways are examined, and the single-port slot memory and the one
// comparator keep that walk serial. The result register lets a new request enter while the last
// result waits, and the apply step waits only if that register is still full and out_stall is
// high. Valid bits are flops cleared by reset, so no clearing pass is needed.
module hashed_device_code_table_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hdct_pkg::KIND_W-1:0]   in_kind,
  input  logic [hdct_pkg::CODE_W-1:0]   in_device_code,
  input  logic [hdct_pkg::HANDLE_W-1:0] in_device_handle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hdct_pkg::STATUS_W-1:0] out_status,
  output logic [hdct_pkg::HANDLE_W-1:0] out_found_handle,
  output logic [hdct_pkg::COUNT_W-1:0]  out_live_count
);

  `include "assert_macros.svh"

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  localparam logic [hdct_pkg::WAY_W-1:0] WAY_LAST = hdct_pkg::WAY_W'(hdct_pkg::WAYS - 1);

  logic [1:0]                      state_r, state_nxt;
  logic [hdct_pkg::KIND_W-1:0]     kind_r, kind_nxt;
  logic [hdct_pkg::CODE_W-1:0]     code_r, code_nxt;
  logic [hdct_pkg::HANDLE_W-1:0]   handle_r, handle_nxt;
  logic [hdct_pkg::BUCKET_W-1:0]   bucket_r, bucket_nxt;
  logic [hdct_pkg::WAY_W-1:0]      way_r, way_nxt;
  logic                            hit_r, hit_nxt;
  logic [hdct_pkg::WAY_W-1:0]      hit_way_r, hit_way_nxt;
  logic [hdct_pkg::HANDLE_W-1:0]   hit_handle_r, hit_handle_nxt;
  logic                            free_r, free_nxt;
  logic [hdct_pkg::WAY_W-1:0]      free_way_r, free_way_nxt;
  logic [hdct_pkg::COUNT_W-1:0]    count_r, count_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [hdct_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [hdct_pkg::HANDLE_W-1:0]   out_handle_r, out_handle_nxt;
  logic [hdct_pkg::COUNT_W-1:0]    out_count_r, out_count_nxt;

  logic                            out_free;
  logic                            code_match;
  logic                            add_ok;
  logic                            remove_ok;
  logic [hdct_pkg::STATUS_W-1:0]   res_status;
  logic [hdct_pkg::HANDLE_W-1:0]   res_handle;
  logic [hdct_pkg::SLOT_W-1:0]     rd_idx;
  hdct_pkg::slot_rd_t              rd;
  hdct_pkg::slot_wr_t              wr;

  // slot storage
  hdct_slot_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (rd_idx),
    .rd     (rd),
    .wr     (wr)
  );

  assign rd_idx     = hdct_pkg::slot_of(bucket_r, way_r);
  assign in_stall   = (state_r != S_IDLE);
  assign out_free   = !out_valid_r || !out_stall;

  // shared compare unit: one way per visit
  assign code_match = rd.vld && (rd.code == code_r);

  // outcome of the request once the bucket walk is done
  always_comb begin
    add_ok     = 1'b0;
    remove_ok  = 1'b0;
    res_status = hdct_pkg::ST_MISS;
    res_handle = '0;
    case (kind_r)
      hdct_pkg::KIND_LOOKUP: begin
        if (hit_r) begin
          res_status = hdct_pkg::ST_OK;
          res_handle = hit_handle_r;
        end
      end
      hdct_pkg::KIND_ADD: begin
        if (hit_r) begin
          res_status = hdct_pkg::ST_DUP;
        end else if (free_r) begin
          res_status = hdct_pkg::ST_OK;
          add_ok     = 1'b1;
        end else begin
          res_status = hdct_pkg::ST_FULL;
        end
      end
      hdct_pkg::KIND_REMOVE: begin
        if (hit_r) begin
          res_status = hdct_pkg::ST_OK;
          remove_ok  = 1'b1;
        end
      end
      default: begin
        res_status = hdct_pkg::ST_MISS;
      end
    endcase
  end

  // store update, issued on the cycle the result is loaded
  always_comb begin
    wr.fill   = (state_r == S_APPLY) && out_free && add_ok;
    wr.drop   = (state_r == S_APPLY) && out_free && remove_ok;
    wr.idx    = hdct_pkg::slot_of(bucket_r, add_ok ? free_way_r : hit_way_r);
    wr.code   = code_r;
    wr.handle = handle_r;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    code_nxt       = code_r;
    handle_nxt     = handle_r;
    bucket_nxt     = bucket_r;
    way_nxt        = way_r;
    hit_nxt        = hit_r;
    hit_way_nxt    = hit_way_r;
    hit_handle_nxt = hit_handle_r;
    free_nxt       = free_r;
    free_way_nxt   = free_way_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_count_nxt  = out_count_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt   = in_kind;
          code_nxt   = in_device_code;
          handle_nxt = in_device_handle;
          bucket_nxt = hdct_pkg::BUCKET_W'(in_device_code % 64'(hdct_pkg::BUCKETS));
          way_nxt    = '0;
          hit_nxt    = 1'b0;
          free_nxt   = 1'b0;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (code_match) begin
          hit_nxt        = 1'b1;
          hit_way_nxt    = way_r;
          hit_handle_nxt = rd.handle;
        end
        // remember the lowest free way
        if (!rd.vld && !free_r) begin
          free_nxt     = 1'b1;
          free_way_nxt = way_r;
        end
        if (code_match || (way_r == WAY_LAST)) begin
          state_nxt = S_APPLY;
        end else begin
          way_nxt   = way_r + hdct_pkg::WAY_W'(1);
          state_nxt = S_READ;
        end
      end
      S_APPLY: begin
        if (out_free) begin
          if (add_ok) begin
            count_nxt = count_r + hdct_pkg::COUNT_W'(1);
          end else if (remove_ok) begin
            count_nxt = count_r - hdct_pkg::COUNT_W'(1);
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status;
          out_handle_nxt = res_handle;
          out_count_nxt  = count_nxt;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    code_r       <= code_nxt;
    handle_r     <= handle_nxt;
    bucket_r     <= bucket_nxt;
    way_r        <= way_nxt;
    hit_r        <= hit_nxt;
    hit_way_r    <= hit_way_nxt;
    hit_handle_r <= hit_handle_nxt;
    free_r       <= free_nxt;
    free_way_r   <= free_way_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_handle = out_handle_r;
  assign out_live_count   = out_count_r;

  // checks
  `ASSERT_NEXT(a_accept_starts_walk, clk, rst_n, in_valid && !in_stall, state_r == S_READ)
  `ASSERT_SAME(a_result_from_apply, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_APPLY)
  `ASSERT_SAME(a_handle_ok, clk, rst_n, out_valid_r && |out_handle_r, out_status_r == 2'(0))
  `ASSERT_SAME(a_fill_in_apply, clk, rst_n, wr.fill, (state_r == S_APPLY) && !wr.drop)
  `ASSERT_SAME(a_drop_in_apply, clk, rst_n, wr.drop, state_r == S_APPLY)

endmodule

### src/hdct_slot_store.sv
// slot store: code/handle memory with registered read, plus per-slot valid flops
// depends on hdct_pkg
module hdct_slot_store (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [hdct_pkg::SLOT_W-1:0] rd_idx,
  output hdct_pkg::slot_rd_t       rd,
  input  hdct_pkg::slot_wr_t       wr
);

  logic [hdct_pkg::CODE_W-1:0]   code_mem [hdct_pkg::SLOTS];
  logic [hdct_pkg::HANDLE_W-1:0] handle_mem [hdct_pkg::SLOTS];
  logic [hdct_pkg::SLOTS-1:0]    vld_r;
  logic [hdct_pkg::SLOTS-1:0]    vld_nxt;
  logic                          rd_vld_r;
  logic [hdct_pkg::CODE_W-1:0]   rd_code_r;
  logic [hdct_pkg::HANDLE_W-1:0] rd_handle_r;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr.fill) begin
      code_mem[wr.idx]   <= wr.code;
      handle_mem[wr.idx] <= wr.handle;
    end
    rd_code_r   <= code_mem[rd_idx];
    rd_handle_r <= handle_mem[rd_idx];
  end

  // valid bits, cleared at reset
  always_comb begin
    vld_nxt = vld_r;
    if (wr.fill) begin
      vld_nxt[wr.idx] = 1'b1;
    end else if (wr.drop) begin
      vld_nxt[wr.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      rd_vld_r <= vld_r[rd_idx];
    end
  end

  assign rd = '{vld: rd_vld_r, code: rd_code_r, handle: rd_handle_r};

endmodule
